// ===== hdl/rtsc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rtsc_pkg: shared types and constants of the ROC threshold sweep counter
// Field widths, item function codes and the command and status bundles
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package rtsc_pkg;

  localparam int FUNC_W      = 2;
  localparam int INDEX_W     = 10;
  localparam int VALUE_W     = 16;
  localparam int LABEL_W     = 16;
  localparam int RATE_W      = 17;
  localparam int OUT_COUNT_W = 32;
  localparam int CFG_W       = 11;
  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_SAMPLE = 2'd1,
    FUNC_READ   = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_t;

  typedef struct packed {
    logic capture;       // latch the payload of the accepted item
    logic load_we;       // write a threshold slot
    logic sample_start;  // bump a total and arm the sweep
    logic clear_start;   // zero the totals and arm the clearing pass
    logic sweep_run;     // sweep the threshold table
    logic rd_issue;      // read the counts of the requested slot
    logic div_start;     // start both rate divisions
    logic clear_run;     // zero one count slot
    logic out_load;      // load the result register
  } cmd_t;

  typedef struct packed {
    logic sweep_done;
    logic clear_last;
    logic div_done;
  } status_t;

endpackage
`default_nettype wire

// ===== hdl/rtsc_channels.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rtsc_channels: valid/ready channels of the ROC threshold sweep counter
// Input item channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface rtsc_item_if;
  logic                            valid;
  logic                            ready;
  logic [rtsc_pkg::FUNC_W-1:0]     func;
  logic [rtsc_pkg::INDEX_W-1:0]    index;
  logic [rtsc_pkg::VALUE_W-1:0]    value;
  logic [rtsc_pkg::LABEL_W-1:0]    label_a;
  logic [rtsc_pkg::LABEL_W-1:0]    label_b;
  modport source (output valid, func, index, value, label_a, label_b, input ready);
  modport sink   (input valid, func, index, value, label_a, label_b, output ready);
endinterface

interface rtsc_result_if;
  logic                              valid;
  logic                              ready;
  logic [rtsc_pkg::RATE_W-1:0]       true_pos_rate;
  logic [rtsc_pkg::RATE_W-1:0]       false_pos_rate;
  logic [rtsc_pkg::OUT_COUNT_W-1:0]  true_pos;
  logic [rtsc_pkg::OUT_COUNT_W-1:0]  false_pos;
  logic                              no_positives;
  logic                              no_negatives;
  modport source (output valid, true_pos_rate, false_pos_rate, true_pos, false_pos,
                  no_positives, no_negatives, input ready);
  modport sink   (input valid, true_pos_rate, false_pos_rate, true_pos, false_pos,
                  no_positives, no_negatives, output ready);
endinterface

interface rtsc_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [rtsc_pkg::CFG_W-1:0]  data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/rtsc_divider.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rtsc_divider: restoring divider for Q16 rates
// Computes floor(min(part, whole) * 65536 / whole), one quotient bit a cycle.
// ----------------------------------------------------------------------------
module rtsc_divider #(
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [COUNT_WIDTH-1:0]      part,
  input  wire logic [COUNT_WIDTH-1:0]      whole,
  output logic      [rtsc_pkg::RATE_W-1:0] quotient,
  output logic                             done
);

  localparam int RW    = rtsc_pkg::RATE_W;
  localparam int STEPW = $clog2(RW);

  logic [COUNT_WIDTH:0]   rem;
  logic [COUNT_WIDTH-1:0] den;
  logic [STEPW-1:0]       step;
  logic                   busy;
  logic                   ge;
  logic [COUNT_WIDTH:0]   diff;

  assign ge   = rem >= {1'b0, den};
  assign diff = ge ? rem - {1'b0, den} : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        step     <= STEPW'(RW - 1);
        rem      <= {1'b0, (part > whole) ? whole : part};
        den      <= whole;
        quotient <= '0;
      end else if (busy) begin
        quotient <= {quotient[RW-2:0], ge};
        // The remainder after a subtraction is below the divisor, so the shift fits.
        rem      <= {diff[COUNT_WIDTH-1:0], 1'b0};
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/rtsc_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rtsc_datapath: tables, counters and rate units of the sweep counter
// Holds the threshold memory, the count memory, the class totals, the sweep
// and clearing counters, the two rate dividers and the result register.
// ----------------------------------------------------------------------------
module rtsc_datapath #(
  parameter int MAX_THRESHOLDS = 1024,
  parameter int COUNT_WIDTH    = 32,
  parameter int SCORE_WIDTH    = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire rtsc_pkg::cmd_t                   cmd,
  output rtsc_pkg::status_t                     status,
  input  wire logic [rtsc_pkg::INDEX_W-1:0]     index,
  input  wire logic [rtsc_pkg::VALUE_W-1:0]     value,
  input  wire logic [rtsc_pkg::LABEL_W-1:0]     label_a,
  input  wire logic [rtsc_pkg::LABEL_W-1:0]     label_b,
  input  wire logic                             cfg_we,
  input  wire logic [rtsc_pkg::CFG_W-1:0]       cfg_data,
  output logic      [rtsc_pkg::RATE_W-1:0]      true_pos_rate,
  output logic      [rtsc_pkg::RATE_W-1:0]      false_pos_rate,
  output logic      [rtsc_pkg::OUT_COUNT_W-1:0] true_pos,
  output logic      [rtsc_pkg::OUT_COUNT_W-1:0] false_pos,
  output logic                                  no_positives,
  output logic                                  no_negatives
);

  localparam int AW = (MAX_THRESHOLDS > 1) ? $clog2(MAX_THRESHOLDS) : 1;
  localparam int NW = $clog2(MAX_THRESHOLDS + 1);
  localparam int CW = COUNT_WIDTH;

  logic [SCORE_WIDTH-1:0] thr_mem [MAX_THRESHOLDS];
  logic [2*CW-1:0]        cnt_mem [MAX_THRESHOLDS];

  logic [rtsc_pkg::CFG_W-1:0] threshold_count;
  logic [CW-1:0]              positive_total;
  logic [CW-1:0]              negative_total;

  logic [SCORE_WIDTH-1:0] score;
  logic                   pos;
  logic [AW-1:0]          idx;
  logic                   idx_ok;
  logic [NW-1:0]          sweep_len;
  logic [NW-1:0]          rd_cnt;
  logic                   s1_valid;
  logic [AW-1:0]          s1_addr;
  logic [AW-1:0]          clr_cnt;
  logic [SCORE_WIDTH-1:0] thr_rd;
  logic [2*CW-1:0]        cnt_rd;
  logic [CW-1:0]          tp_part;
  logic [CW-1:0]          fp_part;

  logic                   pos_in;
  logic                   idx_ok_in;
  logic [NW-1:0]          sweep_len_in;
  logic                   issue;
  logic [AW-1:0]          cnt_rd_addr;
  logic [CW-1:0]          tp_old;
  logic [CW-1:0]          fp_old;
  logic [CW-1:0]          tp_inc;
  logic [CW-1:0]          fp_inc;
  logic                   hit;
  logic                   cnt_we;
  logic [AW-1:0]          cnt_wr_addr;
  logic [2*CW-1:0]        cnt_wr_data;
  logic [rtsc_pkg::RATE_W-1:0] tp_q;
  logic [rtsc_pkg::RATE_W-1:0] fp_q;
  logic                   tp_done;
  logic                   fp_done;

  assign pos_in       = label_a == label_b;
  assign idx_ok_in    = 32'(index) < 32'(MAX_THRESHOLDS);
  assign sweep_len_in = (32'(threshold_count) > 32'(MAX_THRESHOLDS)) ?
                        NW'(MAX_THRESHOLDS) : NW'(threshold_count);

  assign issue       = cmd.sweep_run && (rd_cnt != sweep_len);
  assign cnt_rd_addr = cmd.rd_issue ? idx : rd_cnt[AW-1:0];

  assign tp_old = cnt_rd[2*CW-1:CW];
  assign fp_old = cnt_rd[CW-1:0];
  assign tp_inc = (&tp_old) ? tp_old : tp_old + 1'b1;
  assign fp_inc = (&fp_old) ? fp_old : fp_old + 1'b1;
  assign hit    = score <= thr_rd;

  always_comb begin
    if (cmd.clear_run) begin
      cnt_we      = 1'b1;
      cnt_wr_addr = clr_cnt;
      cnt_wr_data = '0;
    end else begin
      cnt_we      = s1_valid && hit;
      cnt_wr_addr = s1_addr;
      cnt_wr_data = pos ? {tp_inc, fp_old} : {tp_old, fp_inc};
    end
  end

  assign status.sweep_done = cmd.sweep_run && (rd_cnt == sweep_len) && !s1_valid;
  assign status.clear_last = cmd.clear_run && (clr_cnt == AW'(MAX_THRESHOLDS - 1));
  assign status.div_done   = tp_done && fp_done;

  // Memories.
  always_ff @(posedge clk) begin
    if (cmd.load_we && idx_ok_in) begin
      thr_mem[AW'(index)] <= SCORE_WIDTH'(value);
    end
    if (issue) begin
      thr_rd <= thr_mem[rd_cnt[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_wr_addr] <= cnt_wr_data;
    end
    if (issue || cmd.rd_issue) begin
      cnt_rd <= cnt_mem[cnt_rd_addr];
    end
  end

  // Control counters, totals and the configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_count <= rtsc_pkg::CFG_RESET;
      positive_total  <= '0;
      negative_total  <= '0;
      rd_cnt          <= '0;
      s1_valid        <= 1'b0;
      clr_cnt         <= '0;
    end else begin
      if (cfg_we) begin
        threshold_count <= cfg_data;
      end
      if (cmd.clear_start) begin
        positive_total <= '0;
        negative_total <= '0;
        clr_cnt        <= '0;
      end else if (cmd.clear_run) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cmd.sample_start) begin
        rd_cnt <= '0;
        if (pos_in) begin
          positive_total <= (&positive_total) ? positive_total : positive_total + 1'b1;
        end else begin
          negative_total <= (&negative_total) ? negative_total : negative_total + 1'b1;
        end
      end else if (issue) begin
        rd_cnt <= rd_cnt + 1'b1;
      end
      s1_valid <= issue;
    end
  end

  // Item payload and pipeline payload.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      score     <= SCORE_WIDTH'(value);
      pos       <= pos_in;
      idx       <= AW'(index);
      idx_ok    <= idx_ok_in;
      sweep_len <= sweep_len_in;
    end
    if (issue) begin
      s1_addr <= rd_cnt[AW-1:0];
    end
    if (cmd.div_start) begin
      tp_part <= idx_ok ? tp_old : '0;
      fp_part <= idx_ok ? fp_old : '0;
    end
  end

  rtsc_divider #(.COUNT_WIDTH(CW)) u_tp_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .part     (idx_ok ? tp_old : '0),
    .whole    (positive_total),
    .quotient (tp_q),
    .done     (tp_done)
  );

  rtsc_divider #(.COUNT_WIDTH(CW)) u_fp_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .part     (idx_ok ? fp_old : '0),
    .whole    (negative_total),
    .quotient (fp_q),
    .done     (fp_done)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      true_pos_rate  <= (positive_total == '0) ? '0 : tp_q;
      false_pos_rate <= (negative_total == '0) ? '0 : fp_q;
      true_pos       <= rtsc_pkg::OUT_COUNT_W'(tp_part);
      false_pos      <= rtsc_pkg::OUT_COUNT_W'(fp_part);
      no_positives   <= positive_total == '0;
      no_negatives   <= negative_total == '0;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/rtsc_controller.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rtsc_controller: sequencer of the ROC threshold sweep counter
// Accepts one item at a time, steps the datapath through sweeps, reads and
// clearing passes, and owns the result valid flag.
// ----------------------------------------------------------------------------
module rtsc_controller (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [rtsc_pkg::FUNC_W-1:0] func,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output rtsc_pkg::cmd_t                   cmd,
  input  wire rtsc_pkg::status_t           status
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP,
    ST_RD_ISSUE,
    ST_RD_START,
    ST_DIV,
    ST_RESULT
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = state == ST_IDLE;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd              = '0;
    cmd.capture      = accept;
    cmd.load_we      = accept && (func == rtsc_pkg::FUNC_LOAD);
    cmd.sample_start = accept && (func == rtsc_pkg::FUNC_SAMPLE);
    cmd.clear_start  = accept && (func == rtsc_pkg::FUNC_CLEAR);
    cmd.sweep_run    = state == ST_SWEEP;
    cmd.rd_issue     = state == ST_RD_ISSUE;
    cmd.div_start    = state == ST_RD_START;
    cmd.clear_run    = state == ST_CLEAR;
    cmd.out_load     = (state == ST_RESULT) && (!out_valid || out_ready);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (status.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (rtsc_pkg::func_t'(func))
            rtsc_pkg::FUNC_SAMPLE: state_next = ST_SWEEP;
            rtsc_pkg::FUNC_READ:   state_next = ST_RD_ISSUE;
            rtsc_pkg::FUNC_CLEAR:  state_next = ST_CLEAR;
            default:               state_next = ST_IDLE;
          endcase
        end
      end
      ST_SWEEP: begin
        if (status.sweep_done) state_next = ST_IDLE;
      end
      ST_RD_ISSUE: state_next = ST_RD_START;
      ST_RD_START: state_next = ST_DIV;
      ST_DIV: begin
        if (status.div_done) state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (cmd.out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/roc_threshold_sweep_counter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// roc_threshold_sweep_counter: ROC confusion counts over a threshold table
// Top level: joins the item, result and configuration channels to the
// controller and the datapath.
// ----------------------------------------------------------------------------
// The block accepts one item at a time on the item channel. A load item writes
// one threshold slot. A sample item sweeps the first N slots, where N is
// threshold_count limited to MAX_THRESHOLDS: the sweep walks the threshold
// memory and the count memory one slot a cycle, reading a slot while the
// update of the previous slot is written back. A read item waits on the two
// 17-step Q16 dividers that run side by side; its result sits in an output
// register, so the next item is taken while that result still waits. A clear
// item, and likewise reset, starts a clearing pass over all MAX_THRESHOLDS
// slots that zeroes the count memory one slot a cycle; no item is taken
// during it, while configuration writes are always taken.
// Slots of the threshold table that were never loaded hold unknown values.
// ----------------------------------------------------------------------------
module roc_threshold_sweep_counter #(
  parameter int MAX_THRESHOLDS = 1024,
  parameter int COUNT_WIDTH    = 32,
  parameter int SCORE_WIDTH    = 16
) (
  input  wire logic    clk,
  input  wire logic    rst,
  rtsc_cfg_if.sink     cfg,
  rtsc_item_if.sink    item,
  rtsc_result_if.source result
);

  rtsc_pkg::cmd_t    cmd;
  rtsc_pkg::status_t status;

  // The single register is a plain write; every transfer is taken at once.
  assign cfg.ready = 1'b1;

  // The controller sequences every item and owns both handshake flags.
  rtsc_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .func      (item.func),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd),
    .status    (status)
  );

  // The datapath holds both memories, the totals, the dividers and the
  // result payload register.
  rtsc_datapath #(
    .MAX_THRESHOLDS (MAX_THRESHOLDS),
    .COUNT_WIDTH    (COUNT_WIDTH),
    .SCORE_WIDTH    (SCORE_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .index          (item.index),
    .value          (item.value),
    .label_a        (item.label_a),
    .label_b        (item.label_b),
    .cfg_we         (cfg.valid && cfg.ready),
    .cfg_data       (cfg.data),
    .true_pos_rate  (result.true_pos_rate),
    .false_pos_rate (result.false_pos_rate),
    .true_pos       (result.true_pos),
    .false_pos      (result.false_pos),
    .no_positives   (result.no_positives),
    .no_negatives   (result.no_negatives)
  );

`ifndef SYNTHESIS
  // No item may be taken while the count memory is being cleared.
  a_no_item_in_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_run |-> !item.ready)
    else $error("item ready during clearing pass");

  // A new result never overwrites one that has not been transferred.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!result.valid || result.ready))
    else $error("result register overwritten");

  // The result valid flag rises only after a result load.
  a_valid_from_load: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !$past(result.valid)) |-> $past(cmd.out_load))
    else $error("result valid without a load");

  // The end of a sweep returns the block to idle.
  a_sweep_to_idle: assert property (@(posedge clk) disable iff (rst)
    status.sweep_done |=> item.ready)
    else $error("block not idle after sweep");
`endif

endmodule
`default_nettype wire
